### sv/transformed_bounding_box_macros.svh
// ----------------------------------------------------------------------------
// transformed_bounding_box_macros.svh
// Assertion macros shared by the bounding box modules.
// ----------------------------------------------------------------------------
`ifndef TRANSFORMED_BOUNDING_BOX_MACROS_SVH
`define TRANSFORMED_BOUNDING_BOX_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define TBB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bounding box check failed");

// Next-cycle implication, checked while out of reset.
`define TBB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bounding box check failed");

`endif

### sv/tbb_pkg.sv
// ----------------------------------------------------------------------------
// tbb_pkg
// Types and constants shared by the transformed bounding box modules.
// ----------------------------------------------------------------------------
package tbb_pkg;

    // Saturation limits of the signed Q16.16 results.
    localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] NEG_MIN = 32'sh8000_0000;

    // Configuration register indexes and reset values.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_Z = 2'd2;
    localparam logic [63:0] ROW_X_RESET = 64'h0000_0000_0000_0100;
    localparam logic [63:0] ROW_Y_RESET = 64'h0000_0000_0100_0000;
    localparam logic [63:0] ROW_Z_RESET = 64'h0000_0100_0000_0000;

    // Item codes.
    localparam logic ACTION_ADD    = 1'b0;
    localparam logic ACTION_FINISH = 1'b1;

    // Queue between the transform front end and the box back end.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 3);

    typedef logic [63:0] row_t;

    typedef struct packed {
        logic               action;
        logic signed [15:0] vertex_x;
        logic signed [15:0] vertex_y;
        logic signed [15:0] vertex_z;
    } vertex_word_t;

    typedef struct packed {
        logic signed [31:0] box_min_x;
        logic signed [31:0] box_min_y;
        logic signed [31:0] box_min_z;
        logic signed [31:0] box_max_x;
        logic signed [31:0] box_max_y;
        logic signed [31:0] box_max_z;
        logic               box_empty;
    } box_word_t;

    typedef struct packed {
        logic               finish;
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic signed [31:0] tz;
    } queue_entry_t;

endpackage

### sv/tbb_front.sv
// ----------------------------------------------------------------------------
// tbb_front
// Accepts vertex words and transforms them in two stages: products, then
// sum with saturation. Admission is credit based on queue room.
// ----------------------------------------------------------------------------
`include "transformed_bounding_box_macros.svh"

module tbb_front #(
    parameter int COORD_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        vertex_valid,
    output logic                        vertex_ready,
    input  tbb_pkg::vertex_word_t       vertex,
    input  tbb_pkg::row_t               row_x,
    input  tbb_pkg::row_t               row_y,
    input  tbb_pkg::row_t               row_z,
    input  logic [tbb_pkg::QCNT_W-1:0]  queue_count,
    output logic                        push,
    output tbb_pkg::queue_entry_t       push_entry
);

    localparam int PW = 16 + COORD_BITS;
    localparam int SW = PW + 2;

    logic                         accept;
    logic [tbb_pkg::QCNT_W-1:0]   busy;
    tbb_pkg::row_t                rows [3];
    logic signed [15:0]           coef [3][4];
    logic signed [COORD_BITS-1:0] coord [3];
    logic signed [PW-1:0]         prod_next [3][3];
    logic signed [PW-1:0]         prod_reg [3][3];
    logic signed [SW-1:0]         sum [3];
    logic signed [31:0]           sat [3];
    logic                         s1_valid_reg;
    logic                         s1_valid_next;
    logic                         s1_finish_reg;
    logic                         s2_valid_reg;
    tbb_pkg::queue_entry_t        s2_entry_reg;
    tbb_pkg::queue_entry_t        s2_entry_next;

    // Room check: queue words plus words still in the two stages.
    assign busy = queue_count + tbb_pkg::QCNT_W'(s1_valid_reg)
                + tbb_pkg::QCNT_W'(s2_valid_reg);
    assign vertex_ready = busy < tbb_pkg::QCNT_W'(tbb_pkg::QUEUE_DEPTH);
    assign accept = vertex_valid && vertex_ready;

    assign rows[0] = row_x;
    assign rows[1] = row_y;
    assign rows[2] = row_z;

    // Coordinates: low COORD_BITS bits, two's complement; wider widths zero-extend.
    generate
        if (COORD_BITS <= 16) begin : g_narrow
            assign coord[0] = vertex.vertex_x[COORD_BITS-1:0];
            assign coord[1] = vertex.vertex_y[COORD_BITS-1:0];
            assign coord[2] = vertex.vertex_z[COORD_BITS-1:0];
        end
        else begin : g_wide
            assign coord[0] = {{(COORD_BITS-16){1'b0}}, vertex.vertex_x};
            assign coord[1] = {{(COORD_BITS-16){1'b0}}, vertex.vertex_y};
            assign coord[2] = {{(COORD_BITS-16){1'b0}}, vertex.vertex_z};
        end
    endgenerate

    // Unpack the Q8.8 coefficient words and form the nine products.
    generate
        for (genvar a = 0; a < 3; a++) begin : g_axis
            for (genvar k = 0; k < 4; k++) begin : g_word
                assign coef[a][k] = rows[a][16*k +: 16];
            end
            for (genvar k = 0; k < 3; k++) begin : g_prod
                assign prod_next[a][k] = PW'(coef[a][k]) * PW'(coord[k]);
            end
        end
    endgenerate

    // Second stage: add the products and the shifted translation, then saturate.
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            sum[a] = SW'(prod_reg[a][0]) + SW'(prod_reg[a][1]) + SW'(prod_reg[a][2])
                   + (SW'(coef[a][3]) <<< 8);
            if (sum[a] > SW'(tbb_pkg::POS_MAX))
                sat[a] = tbb_pkg::POS_MAX;
            else if (sum[a] < SW'(tbb_pkg::NEG_MIN))
                sat[a] = tbb_pkg::NEG_MIN;
            else
                sat[a] = sum[a][31:0];
        end
        s2_entry_next.finish = s1_finish_reg;
        s2_entry_next.tx     = sat[0];
        s2_entry_next.ty     = sat[1];
        s2_entry_next.tz     = sat[2];
    end

    assign s1_valid_next = accept;

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Stage payloads; the pipeline never stalls, so they load every cycle.
    always_ff @(posedge clk)
    begin
        prod_reg      <= prod_next;
        s1_finish_reg <= (vertex.action == tbb_pkg::ACTION_FINISH);
        s2_entry_reg  <= s2_entry_next;
    end

    assign push       = s2_valid_reg;
    assign push_entry = s2_entry_reg;

    // Words in flight never exceed the queue room.
    `TBB_ASSERT_NOW(a_credit_bound, clk, rst_n, 1'b1, busy <= tbb_pkg::QCNT_W'(tbb_pkg::QUEUE_DEPTH))

endmodule

### sv/tbb_queue.sv
// ----------------------------------------------------------------------------
// tbb_queue
// Short first-in first-out queue of transformed words between the front
// end and the box back end.
// ----------------------------------------------------------------------------
`include "transformed_bounding_box_macros.svh"

module tbb_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  tbb_pkg::queue_entry_t       push_entry,
    input  logic                        pop,
    output logic                        head_valid,
    output tbb_pkg::queue_entry_t       head,
    output logic [tbb_pkg::QCNT_W-1:0]  count
);

    tbb_pkg::queue_entry_t        slot_reg [tbb_pkg::QUEUE_DEPTH];
    logic [tbb_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [tbb_pkg::QPTR_W-1:0]   wr_ptr_next;
    logic [tbb_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [tbb_pkg::QPTR_W-1:0]   rd_ptr_next;
    logic [tbb_pkg::QCNT_W-1:0]   count_reg;
    logic [tbb_pkg::QCNT_W-1:0]   count_next;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + tbb_pkg::QCNT_W'(push) - tbb_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Slot storage.
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    assign head       = slot_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign count      = count_reg;

    `TBB_ASSERT_NOW(a_no_overflow, clk, rst_n, count_reg == tbb_pkg::QCNT_W'(tbb_pkg::QUEUE_DEPTH), !push)
    `TBB_ASSERT_NOW(a_no_underflow, clk, rst_n, pop, count_reg != '0)

endmodule

### sv/tbb_back.sv
// ----------------------------------------------------------------------------
// tbb_back
// Keeps the running box of transformed vertices and emits it on a finish
// word through an output register.
// ----------------------------------------------------------------------------
`include "transformed_bounding_box_macros.svh"

module tbb_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   head_valid,
    input  tbb_pkg::queue_entry_t  head,
    output logic                   pop,
    output logic                   box_valid,
    input  logic                   box_ready,
    output tbb_pkg::box_word_t     box
);

    logic                  can_emit;
    logic                  add_pop;
    logic                  finish_pop;
    logic signed [31:0]    least_x_reg, least_y_reg, least_z_reg;
    logic signed [31:0]    least_x_next, least_y_next, least_z_next;
    logic signed [31:0]    greatest_x_reg, greatest_y_reg, greatest_z_reg;
    logic signed [31:0]    greatest_x_next, greatest_y_next, greatest_z_next;
    logic                  seen_reg;
    logic                  seen_next;
    logic                  box_valid_reg;
    logic                  box_valid_next;
    tbb_pkg::box_word_t    box_reg;
    tbb_pkg::box_word_t    box_next;

    // A finish word leaves the queue only when the output register frees up.
    assign can_emit   = !box_valid_reg || box_ready;
    assign pop        = head_valid && (!head.finish || can_emit);
    assign add_pop    = pop && !head.finish;
    assign finish_pop = pop && head.finish;

    // Running box update.
    always_comb
    begin
        least_x_next    = least_x_reg;
        least_y_next    = least_y_reg;
        least_z_next    = least_z_reg;
        greatest_x_next = greatest_x_reg;
        greatest_y_next = greatest_y_reg;
        greatest_z_next = greatest_z_reg;
        seen_next       = seen_reg;
        if (add_pop)
        begin
            if (head.tx < least_x_reg)    least_x_next    = head.tx;
            if (head.ty < least_y_reg)    least_y_next    = head.ty;
            if (head.tz < least_z_reg)    least_z_next    = head.tz;
            if (head.tx > greatest_x_reg) greatest_x_next = head.tx;
            if (head.ty > greatest_y_reg) greatest_y_next = head.ty;
            if (head.tz > greatest_z_reg) greatest_z_next = head.tz;
            seen_next = 1'b1;
        end
        else if (finish_pop)
        begin
            least_x_next    = tbb_pkg::POS_MAX;
            least_y_next    = tbb_pkg::POS_MAX;
            least_z_next    = tbb_pkg::POS_MAX;
            greatest_x_next = tbb_pkg::NEG_MIN;
            greatest_y_next = tbb_pkg::NEG_MIN;
            greatest_z_next = tbb_pkg::NEG_MIN;
            seen_next       = 1'b0;
        end
    end

    // Output word and its valid flag.
    always_comb
    begin
        box_next = box_reg;
        if (finish_pop)
        begin
            box_next.box_min_x = least_x_reg;
            box_next.box_min_y = least_y_reg;
            box_next.box_min_z = least_z_reg;
            box_next.box_max_x = greatest_x_reg;
            box_next.box_max_y = greatest_y_reg;
            box_next.box_max_z = greatest_z_reg;
            box_next.box_empty = !seen_reg;
        end
        if (finish_pop)
            box_valid_next = 1'b1;
        else if (box_ready)
            box_valid_next = 1'b0;
        else
            box_valid_next = box_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            least_x_reg    <= tbb_pkg::POS_MAX;
            least_y_reg    <= tbb_pkg::POS_MAX;
            least_z_reg    <= tbb_pkg::POS_MAX;
            greatest_x_reg <= tbb_pkg::NEG_MIN;
            greatest_y_reg <= tbb_pkg::NEG_MIN;
            greatest_z_reg <= tbb_pkg::NEG_MIN;
            seen_reg       <= 1'b0;
            box_valid_reg  <= 1'b0;
        end
        else
        begin
            least_x_reg    <= least_x_next;
            least_y_reg    <= least_y_next;
            least_z_reg    <= least_z_next;
            greatest_x_reg <= greatest_x_next;
            greatest_y_reg <= greatest_y_next;
            greatest_z_reg <= greatest_z_next;
            seen_reg       <= seen_next;
            box_valid_reg  <= box_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        box_reg <= box_next;
    end

    assign box_valid = box_valid_reg;
    assign box       = box_reg;

    `TBB_ASSERT_NEXT(a_finish_emits, clk, rst_n, finish_pop, box_valid_reg && !seen_reg)

endmodule

### sv/transformed_bounding_box.sv
// ----------------------------------------------------------------------------
// transformed_bounding_box
// Axis-aligned bounding box of a vertex stream after an affine transform.
// ----------------------------------------------------------------------------
// Usage:
//   The vertex channel (vertex_valid, vertex_ready, vertex) takes one word per
//   cycle while vertex_ready is high. An add word transforms its Q8.8 vertex by
//   rows row_x, row_y, row_z and widens the running Q16.16 box; a finish word
//   emits the box on the box channel (box_valid, box_ready, box) and clears it.
//   The cfg channel writes a 64-bit row by index; cfg_ready is always high.
//   Rows must be written only while the block is idle.
//   A finish word passes the front end stages, the queue and the output
//   register before it shows on the box channel. Throughput, set by the
//   back end min/max update: one word per cycle while box_ready keeps up.
//   The front end (multiply stage, sum and saturate stage) admits a word only
//   when the 4-entry queue has room for everything in flight.
//   When the receiver stalls, one box waits in the output register, add
//   words keep draining, and the queue fills until vertex_ready drops.
//   Reset loads the identity transform and an empty box.
// ----------------------------------------------------------------------------
module transformed_bounding_box #(
    parameter int COORD_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             vertex_valid,
    output logic                             vertex_ready,
    input  tbb_pkg::vertex_word_t            vertex,
    output logic                             box_valid,
    input  logic                             box_ready,
    output tbb_pkg::box_word_t               box,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tbb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [63:0]                      cfg_data
);

    tbb_pkg::row_t                row_x_reg, row_y_reg, row_z_reg;
    tbb_pkg::row_t                row_x_next, row_y_next, row_z_next;
    logic                         push;
    tbb_pkg::queue_entry_t        push_entry;
    logic                         pop;
    logic                         head_valid;
    tbb_pkg::queue_entry_t        head;
    logic [tbb_pkg::QCNT_W-1:0]   queue_count;

    assign cfg_ready = 1'b1;

    // Transform row decode; an index past the last row is ignored.
    always_comb
    begin
        row_x_next = row_x_reg;
        row_y_next = row_y_reg;
        row_z_next = row_z_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                tbb_pkg::REG_ROW_X: row_x_next = cfg_data;
                tbb_pkg::REG_ROW_Y: row_y_next = cfg_data;
                tbb_pkg::REG_ROW_Z: row_z_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_x_reg <= tbb_pkg::ROW_X_RESET;
            row_y_reg <= tbb_pkg::ROW_Y_RESET;
            row_z_reg <= tbb_pkg::ROW_Z_RESET;
        end
        else
        begin
            row_x_reg <= row_x_next;
            row_y_reg <= row_y_next;
            row_z_reg <= row_z_next;
        end
    end

    tbb_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .vertex_valid (vertex_valid),
        .vertex_ready (vertex_ready),
        .vertex       (vertex),
        .row_x        (row_x_reg),
        .row_y        (row_y_reg),
        .row_z        (row_z_reg),
        .queue_count  (queue_count),
        .push         (push),
        .push_entry   (push_entry)
    );

    tbb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head),
        .count      (queue_count)
    );

    tbb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .box_valid  (box_valid),
        .box_ready  (box_ready),
        .box        (box)
    );

endmodule
